// ===== src/qte_pkg.sv =====
// ----------------------------------------------------------------------------
// qte_pkg
// Shared types and codes for the quote table engine: request and response
// payloads, the token that walks the chain of entry cells, and request codes.
// ----------------------------------------------------------------------------
package qte_pkg;

    // number of entry cells in the chain
    localparam int TABLE_DEPTH = 64;

    // index and count fields in the token are sized for the table
    localparam int SLOT_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] REQ_ADD        = 3'd0;
    localparam logic [2:0] REQ_CANCEL_GRP = 3'd1;
    localparam logic [2:0] REQ_CANCEL_ID  = 3'd2;
    localparam logic [2:0] REQ_EXPIRE     = 3'd3;
    localparam logic [2:0] REQ_FILL       = 3'd4;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PROBE,
        OP_COMMIT,
        OP_CANCEL_GRP,
        OP_CANCEL_ID,
        OP_EXPIRE,
        OP_FILL
    } op_t;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [63:0]        quote_key;
        logic [63:0]        group_key;
        logic [63:0]        dedup_hash;
        logic               bid_present;
        logic               ask_present;
        logic [31:0]        bid_size;
        logic [31:0]        ask_size;
        logic [63:0]        expiry_time;
        logic [63:0]        time_now;
        logic               fill_side;
        logic signed [31:0] fill_size;
    } req_t;

    typedef struct packed {
        logic        accepted;
        logic        did_replace;
        logic        became_filled;
        logic        table_full;
        logic [6:0]  live_count;
        logic [31:0] dup_count;
        logic [31:0] cancel_count;
        logic [31:0] expire_count;
        logic [31:0] replace_count;
    } rsp_t;

    typedef struct packed {
        logic  active;
        op_t   op;
        req_t  req;
        logic  dup;
        logic  grp_hit;
        slot_t grp_idx;
        logic  id_hit;
        slot_t id_idx;
        logic  free_hit;
        slot_t free_idx;
        logic  kill_en;
        slot_t kill_idx;
        logic  wr_en;
        slot_t wr_idx;
        logic  full;
        logic  hit;
        logic  filled;
        cnt_t  count;
        cnt_t  live;
    } token_t;

endpackage

// ===== src/qte_cell.sv =====
// ----------------------------------------------------------------------------
// qte_cell
// One table entry. Applies the passing request token to its entry and hands
// the updated token, registered, to the next cell.
// ----------------------------------------------------------------------------
module qte_cell
    import qte_pkg::*;
#(
    parameter int QTY_BITS = 32,
    parameter int INDEX    = 0
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  token_t tok_in,
    output token_t tok_out
);

    localparam int SUM_W = ((QTY_BITS > 32) ? QTY_BITS : 32) + 1;

    logic                valid_reg, valid_next;
    logic [63:0]         id_reg, id_next;
    logic [63:0]         group_reg, group_next;
    logic [63:0]         hash_reg, hash_next;
    logic [1:0]          sides_reg, sides_next;
    logic [QTY_BITS-1:0] bid_size_reg, bid_size_next;
    logic [QTY_BITS-1:0] ask_size_reg, ask_size_next;
    logic [QTY_BITS-1:0] bid_done_reg, bid_done_next;
    logic [QTY_BITS-1:0] ask_done_reg, ask_done_next;
    logic [63:0]         expiry_reg, expiry_next;
    token_t              tok_reg, tok_next;

    slot_t               me;
    logic                id_match, grp_match, fill_ok;
    logic [SUM_W-1:0]    fill_amt, sum, side_size;
    logic [QTY_BITS-1:0] side_done, new_done;
    logic                bid_ok, ask_ok;

    assign me        = SLOT_W'(INDEX);
    assign id_match  = valid_reg && (id_reg == tok_in.req.quote_key);
    assign grp_match = valid_reg && (group_reg == tok_in.req.group_key);
    assign fill_ok   = !tok_in.req.fill_size[31] && (tok_in.req.fill_size != 32'sd0);
    assign fill_amt  = SUM_W'(unsigned'(tok_in.req.fill_size));
    assign side_done = tok_in.req.fill_side ? ask_done_reg : bid_done_reg;
    assign side_size = SUM_W'(tok_in.req.fill_side ? ask_size_reg : bid_size_reg);
    assign sum       = SUM_W'(side_done) + fill_amt;
    assign new_done  = (sum < side_size) ? sum[QTY_BITS-1:0] : side_size[QTY_BITS-1:0];
    assign bid_ok    = !sides_reg[0] ||
                       ((tok_in.req.fill_side ? bid_done_reg : new_done) >= bid_size_reg);
    assign ask_ok    = !sides_reg[1] ||
                       ((tok_in.req.fill_side ? new_done : ask_done_reg) >= ask_size_reg);

    always_comb begin
        tok_next      = tok_in;
        valid_next    = valid_reg;
        id_next       = id_reg;
        group_next    = group_reg;
        hash_next     = hash_reg;
        sides_next    = sides_reg;
        bid_size_next = bid_size_reg;
        ask_size_next = ask_size_reg;
        bid_done_next = bid_done_reg;
        ask_done_next = ask_done_reg;
        expiry_next   = expiry_reg;
        if (tok_in.active) begin
            case (tok_in.op)
                OP_PROBE: begin
                    if (valid_reg && (tok_in.req.dedup_hash != 64'd0) &&
                        (hash_reg == tok_in.req.dedup_hash)) begin
                        tok_next.dup = 1'b1;
                    end
                    if (grp_match) begin
                        tok_next.grp_hit = 1'b1;
                        tok_next.grp_idx = me;
                    end else if (id_match) begin
                        tok_next.id_hit = 1'b1;
                        tok_next.id_idx = me;
                    end
                    if (!valid_reg && !tok_in.free_hit) begin
                        tok_next.free_hit = 1'b1;
                        tok_next.free_idx = me;
                    end
                end
                OP_COMMIT: begin
                    if (tok_in.kill_en && (tok_in.kill_idx == me)) begin
                        valid_next = 1'b0;
                    end
                    if (tok_in.wr_en && (tok_in.wr_idx == me)) begin
                        valid_next    = 1'b1;
                        id_next       = tok_in.req.quote_key;
                        group_next    = tok_in.req.group_key;
                        hash_next     = tok_in.req.dedup_hash;
                        sides_next    = {tok_in.req.ask_present, tok_in.req.bid_present};
                        bid_size_next = QTY_BITS'(tok_in.req.bid_size);
                        ask_size_next = QTY_BITS'(tok_in.req.ask_size);
                        bid_done_next = '0;
                        ask_done_next = '0;
                        expiry_next   = tok_in.req.expiry_time;
                    end
                end
                OP_CANCEL_GRP: begin
                    if (grp_match) begin
                        valid_next   = 1'b0;
                        tok_next.hit = 1'b1;
                    end
                end
                OP_CANCEL_ID: begin
                    if (id_match) begin
                        valid_next   = 1'b0;
                        tok_next.hit = 1'b1;
                    end
                end
                OP_EXPIRE: begin
                    if (valid_reg && (expiry_reg != 64'd0) &&
                        (expiry_reg <= tok_in.req.time_now)) begin
                        valid_next     = 1'b0;
                        tok_next.count = tok_in.count + cnt_t'(1);
                    end
                end
                OP_FILL: begin
                    if (id_match && fill_ok &&
                        (tok_in.req.fill_side ? sides_reg[1] : sides_reg[0])) begin
                        tok_next.hit = 1'b1;
                        if (tok_in.req.fill_side) begin
                            ask_done_next = new_done;
                        end else begin
                            bid_done_next = new_done;
                        end
                        if (bid_ok && ask_ok) begin
                            valid_next      = 1'b0;
                            tok_next.filled = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (tok_in.op != OP_PROBE) begin
                tok_next.live = tok_in.live + cnt_t'(valid_next);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg       <= id_next;
        group_reg    <= group_next;
        hash_reg     <= hash_next;
        sides_reg    <= sides_next;
        bid_size_reg <= bid_size_next;
        ask_size_reg <= ask_size_next;
        bid_done_reg <= bid_done_next;
        ask_done_reg <= ask_done_next;
        expiry_reg   <= expiry_next;
    end

    assign tok_out = tok_reg;

endmodule

// ===== src/quote_table_engine.sv =====
// ----------------------------------------------------------------------------
// quote_table_engine
// Table of active two-sided quotes built as a chain of entry cells.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request token walks the chain of
// TABLE_DEPTH entry cells, one cell per cycle. Cancel, expire, fill and unknown
// requests take a single pass; the token at the chain end is registered, then
// the result is registered onto the result channel and the next request is
// taken after that. An add takes two passes (a probe for duplicates, the
// group, the id and a free entry, then the commit) before its result is
// registered in the same way. A new request
// is taken while the previous result still waits on the result channel; the
// block stalls only when a finished result finds the previous one unaccepted.
module quote_table_engine
    import qte_pkg::*;
#(
    parameter int QTY_BITS = 32
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_COMMIT,
        ST_RESP
    } state_t;

    state_t      state_reg, state_next;
    token_t      inj_reg, inj_next;
    token_t      done_reg, done_next;
    logic        m_valid_reg, m_valid_next;
    rsp_t        m_data_reg, m_data_next;
    logic [31:0] dup_reg, dup_next;
    logic [31:0] cancel_reg, cancel_next;
    logic [31:0] expire_reg, expire_next;
    logic [31:0] replace_reg, replace_next;

    token_t      chain [0:TABLE_DEPTH];
    token_t      tail;
    token_t      commit_tok;
    logic        sided, go, tgt_ok;
    slot_t       tgt;
    logic [32:0] exp_sum;
    logic        acc;

    assign chain[0] = inj_reg;
    assign tail     = chain[TABLE_DEPTH];

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        qte_cell #(
            .QTY_BITS (QTY_BITS),
            .INDEX    (i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    // decide the commit of an add from what the probe pass found
    always_comb begin
        sided  = tail.req.bid_present || tail.req.ask_present;
        go     = sided && !tail.dup;
        tgt_ok = 1'b1;
        tgt    = '0;
        if (tail.id_hit) begin
            tgt = tail.id_idx;
        end else if (tail.free_hit && tail.grp_hit) begin
            tgt = (tail.grp_idx < tail.free_idx) ? tail.grp_idx : tail.free_idx;
        end else if (tail.free_hit) begin
            tgt = tail.free_idx;
        end else if (tail.grp_hit) begin
            tgt = tail.grp_idx;
        end else begin
            tgt_ok = 1'b0;
        end
        commit_tok          = tail;
        commit_tok.active   = 1'b1;
        commit_tok.op       = OP_COMMIT;
        commit_tok.dup      = sided && tail.dup;
        commit_tok.kill_en  = go && tail.grp_hit;
        commit_tok.kill_idx = tail.grp_idx;
        commit_tok.wr_en    = go && (tail.req.quote_key != 64'd0) && tgt_ok;
        commit_tok.wr_idx   = tgt;
        commit_tok.full     = go && (tail.req.quote_key != 64'd0) && !tgt_ok;
        commit_tok.live     = '0;
    end

    always_comb begin
        case (done_reg.op)
            OP_COMMIT:                  acc = done_reg.wr_en;
            OP_CANCEL_GRP, OP_CANCEL_ID: acc = done_reg.hit;
            OP_EXPIRE:                  acc = (done_reg.count != '0);
            OP_FILL:                    acc = done_reg.hit;
            default:                    acc = 1'b0;
        endcase
        exp_sum = {1'b0, expire_reg} + 33'(done_reg.count);
    end

    always_comb begin
        state_next      = state_reg;
        inj_next        = inj_reg;
        inj_next.active = 1'b0;
        done_next       = done_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        dup_next        = dup_reg;
        cancel_next     = cancel_reg;
        expire_next     = expire_reg;
        replace_next    = replace_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    inj_next        = '0;
                    inj_next.active = 1'b1;
                    inj_next.req    = s_data;
                    state_next      = ST_COMMIT;
                    case (s_data.req_type)
                        REQ_ADD: begin
                            inj_next.op = OP_PROBE;
                            state_next  = ST_PROBE;
                        end
                        REQ_CANCEL_GRP: inj_next.op = OP_CANCEL_GRP;
                        REQ_CANCEL_ID:  inj_next.op = OP_CANCEL_ID;
                        REQ_EXPIRE:     inj_next.op = OP_EXPIRE;
                        REQ_FILL:       inj_next.op = OP_FILL;
                        default:        inj_next.op = OP_NONE;
                    endcase
                end
            end
            ST_PROBE: begin
                if (tail.active) begin
                    inj_next   = commit_tok;
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (tail.active) begin
                    done_next  = tail;
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                    m_data_next.accepted      = acc;
                    m_data_next.did_replace   = done_reg.kill_en;
                    m_data_next.became_filled = done_reg.filled;
                    m_data_next.table_full    = done_reg.full;
                    m_data_next.live_count    = done_reg.live[6:0];
                    if (done_reg.dup && (dup_reg != '1)) begin
                        dup_next = dup_reg + 32'd1;
                    end
                    if (done_reg.kill_en && (replace_reg != '1)) begin
                        replace_next = replace_reg + 32'd1;
                    end
                    if ((done_reg.op == OP_CANCEL_GRP || done_reg.op == OP_CANCEL_ID) &&
                        done_reg.hit && (cancel_reg != '1)) begin
                        cancel_next = cancel_reg + 32'd1;
                    end
                    // saturating add of the number of expired quotes
                    if (exp_sum[32]) begin
                        expire_next = 32'hFFFF_FFFF;
                    end else begin
                        expire_next = exp_sum[31:0];
                    end
                    m_data_next.dup_count     = dup_next;
                    m_data_next.replace_count = replace_next;
                    m_data_next.cancel_count  = cancel_next;
                    m_data_next.expire_count  = expire_next;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            inj_reg     <= '0;
            done_reg    <= '0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            dup_reg     <= '0;
            cancel_reg  <= '0;
            expire_reg  <= '0;
            replace_reg <= '0;
        end else begin
            state_reg   <= state_next;
            inj_reg     <= inj_next;
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
            m_data_reg  <= m_data_next;
            dup_reg     <= dup_next;
            cancel_reg  <= cancel_next;
            expire_reg  <= expire_next;
            replace_reg <= replace_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
